>>> rtl/core/streaming_word_hash_64_unit_defines.svh
// Assertion macros shared by the hash block.
// Included by the top level; expects clk and rst_n in the including scope.
`ifndef STREAMING_WORD_HASH_64_UNIT_DEFINES_SVH
`define STREAMING_WORD_HASH_64_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SWH_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swh: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SWH_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swh: next-cycle check failed");

`endif

>>> rtl/core/swh_pkg.sv
// Types, constants and the control program of the streaming word hash block.
// No dependencies; used by the interfaces, the multiplier and the top level.
package swh_pkg;

    localparam int WORD_W    = 64;
    localparam int HALF_W    = WORD_W / 2;
    localparam int PROD_W    = 2 * WORD_W;
    localparam int BUF_DEPTH = 6;
    localparam int BUF_AW    = $clog2(BUF_DEPTH);
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
    localparam int REG_IDX_W = 2;
    localparam int STEP_W    = 5;
    localparam int PP_COUNT  = 4;
    localparam int PP_CNT_W  = $clog2(PP_COUNT + 1);

    typedef logic [WORD_W-1:0]    word_t;
    typedef logic [BUF_AW-1:0]    addr_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [STEP_W-1:0]    step_t;
    typedef logic [REG_IDX_W-1:0] reg_idx_raw_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SEED_BASE,
        REG_SECRET_ZERO,
        REG_SECRET_ONE,
        REG_SECRET_TWO
    } reg_idx_t;

    typedef enum logic [1:0] {XS_T, XS_SEED, XS_LO} x_src_t;
    typedef enum logic [1:0] {K_NONE, K_S0, K_S1, K_S2} key_t;
    typedef enum logic [1:0] {YS_RAM, YS_ZERO, YS_HI} y_src_t;
    typedef enum logic [2:0] {L_NONE, L_MAIN, L_ONE, L_TWO, L_S} lane_sel_t;
    typedef enum logic [2:0] {
        WB_NONE, WB_SEED, WB_MAIN, WB_ONE, WB_TWO, WB_S, WB_HASH
    } wb_t;
    typedef enum logic [1:0] {AM_FIXED, AM_TAIL2, AM_TAIL1} addr_mode_t;
    typedef enum logic [2:0] {
        C_NEXT, C_ALWAYS, C_CNT_NZ, C_NO_FOLD, C_NO_LAST, C_N_LE2, C_N_LE4
    } cond_t;
    typedef enum logic [1:0] {CNT_KEEP, CNT_CLEAR, CNT_PUSH} cnt_op_t;

    typedef struct packed {
        logic       rd;
        addr_mode_t amode;
        addr_t      addr;
        logic       ld_t;
        logic       go;
        x_src_t     xs;
        key_t       xk;
        y_src_t     ys;
        lane_sel_t  yl;
        key_t       yk;
        logic       hold_mul;
        wb_t        wb;
        logic       s_init;
        cnt_op_t    cnt_op;
        cond_t      cond;
        step_t      target;
        logic       done;
    } ucode_t;

    localparam step_t L_AFTER_SEED = step_t'(3);
    localparam step_t L_WRITE      = step_t'(13);
    localparam step_t L_TAIL       = step_t'(21);
    localparam step_t L_DONE       = step_t'(27);

    localparam ucode_t UC_NOP = '{
        rd: 1'b0, amode: AM_FIXED, addr: '0, ld_t: 1'b0, go: 1'b0,
        xs: XS_T, xk: K_NONE, ys: YS_RAM, yl: L_NONE, yk: K_NONE,
        hold_mul: 1'b0, wb: WB_NONE, s_init: 1'b0, cnt_op: CNT_KEEP,
        cond: C_NEXT, target: '0, done: 1'b0
    };

    // Control store. Each buffer mix takes two reads, a multiplier start and a wait.
    function automatic ucode_t swh_ucode(step_t step);
        ucode_t uc;
        uc = UC_NOP;
        unique case (step)
            5'd0:
            begin
                uc.cond = C_CNT_NZ; uc.target = L_AFTER_SEED;
            end
            5'd1:
            begin
                uc.go = 1'b1; uc.xs = XS_SEED; uc.xk = K_S0;
                uc.ys = YS_ZERO; uc.yk = K_S1;
            end
            5'd2:
            begin
                uc.hold_mul = 1'b1; uc.wb = WB_SEED;
            end
            5'd3:
            begin
                uc.rd = 1'b1; uc.addr = addr_t'(0);
                uc.cond = C_NO_FOLD; uc.target = L_WRITE;
            end
            5'd4:
            begin
                uc.ld_t = 1'b1; uc.rd = 1'b1; uc.addr = addr_t'(1);
            end
            5'd5:
            begin
                uc.go = 1'b1; uc.xs = XS_T; uc.xk = K_S0; uc.ys = YS_RAM; uc.yl = L_MAIN;
            end
            5'd6:
            begin
                uc.hold_mul = 1'b1; uc.wb = WB_MAIN; uc.rd = 1'b1; uc.addr = addr_t'(2);
            end
            5'd7:
            begin
                uc.ld_t = 1'b1; uc.rd = 1'b1; uc.addr = addr_t'(3);
            end
            5'd8:
            begin
                uc.go = 1'b1; uc.xs = XS_T; uc.xk = K_S1; uc.ys = YS_RAM; uc.yl = L_ONE;
            end
            5'd9:
            begin
                uc.hold_mul = 1'b1; uc.wb = WB_ONE; uc.rd = 1'b1; uc.addr = addr_t'(4);
            end
            5'd10:
            begin
                uc.ld_t = 1'b1; uc.rd = 1'b1; uc.addr = addr_t'(5);
            end
            5'd11:
            begin
                uc.go = 1'b1; uc.xs = XS_T; uc.xk = K_S2; uc.ys = YS_RAM; uc.yl = L_TWO;
            end
            5'd12:
            begin
                uc.hold_mul = 1'b1; uc.wb = WB_TWO; uc.cnt_op = CNT_CLEAR;
            end
            5'd13:
            begin
                uc.cnt_op = CNT_PUSH; uc.cond = C_NO_LAST; uc.target = L_DONE;
            end
            5'd14:
            begin
                uc.s_init = 1'b1; uc.rd = 1'b1; uc.addr = addr_t'(0);
                uc.cond = C_N_LE2; uc.target = L_TAIL;
            end
            5'd15:
            begin
                uc.ld_t = 1'b1; uc.rd = 1'b1; uc.addr = addr_t'(1);
            end
            5'd16:
            begin
                uc.go = 1'b1; uc.xs = XS_T; uc.xk = K_S2;
                uc.ys = YS_RAM; uc.yl = L_S; uc.yk = K_S1;
            end
            5'd17:
            begin
                uc.hold_mul = 1'b1; uc.wb = WB_S; uc.rd = 1'b1; uc.addr = addr_t'(2);
                uc.cond = C_N_LE4; uc.target = L_TAIL;
            end
            5'd18:
            begin
                uc.ld_t = 1'b1; uc.rd = 1'b1; uc.addr = addr_t'(3);
            end
            5'd19:
            begin
                uc.go = 1'b1; uc.xs = XS_T; uc.xk = K_S2; uc.ys = YS_RAM; uc.yl = L_S;
            end
            5'd20:
            begin
                uc.hold_mul = 1'b1; uc.wb = WB_S;
            end
            5'd21:
            begin
                uc.rd = 1'b1; uc.amode = AM_TAIL2;
            end
            5'd22:
            begin
                uc.ld_t = 1'b1; uc.rd = 1'b1; uc.amode = AM_TAIL1;
            end
            5'd23:
            begin
                uc.go = 1'b1; uc.xs = XS_T; uc.xk = K_S1; uc.ys = YS_RAM; uc.yl = L_S;
            end
            5'd24:
            begin
                uc.hold_mul = 1'b1;
            end
            5'd25:
            begin
                uc.go = 1'b1; uc.xs = XS_LO; uc.xk = K_S0; uc.ys = YS_HI; uc.yk = K_S1;
            end
            5'd26:
            begin
                uc.hold_mul = 1'b1; uc.wb = WB_HASH; uc.cnt_op = CNT_CLEAR;
            end
            default:
            begin
                uc.done = 1'b1;
            end
        endcase
        return uc;
    endfunction

endpackage

>>> rtl/core/swh_ifs.sv
// Handshake interfaces of the hash block: message items, hash items and register writes.
// Depends on swh_pkg for the payload types.
interface swh_msg_if;
    logic          valid;
    logic          ready;
    swh_pkg::word_t word;
    logic          has_word;
    logic          last;
    modport source (output valid, word, has_word, last, input ready);
    modport sink (input valid, word, has_word, last, output ready);
endinterface

interface swh_hash_if;
    logic           valid;
    logic           ready;
    swh_pkg::word_t hash;
    modport source (output valid, hash, input ready);
    modport sink (input valid, hash, output ready);
endinterface

interface swh_cfg_if;
    logic                  valid;
    logic                  ready;
    swh_pkg::reg_idx_raw_t index;
    swh_pkg::word_t        data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/swh_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module swh_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 6
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/swh_mul.sv
// Multi-cycle 64x64 to 128-bit multiplier built on one 32x32 partial product per cycle.
// Depends on swh_pkg for widths.
module swh_mul (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  swh_pkg::word_t x,
    input  swh_pkg::word_t y,
    output logic           busy,
    output swh_pkg::word_t lo,
    output swh_pkg::word_t hi
);

    swh_pkg::word_t                 x_reg;
    swh_pkg::word_t                 y_reg;
    swh_pkg::word_t                 pp_reg;
    logic [1:0]                     pp_idx_reg;
    logic                           pp_valid_reg;
    logic [swh_pkg::PROD_W-1:0]     acc_reg;
    logic [swh_pkg::PP_CNT_W-1:0]   cnt_reg;
    logic                           busy_reg;

    logic [swh_pkg::HALF_W-1:0]     ha;
    logic [swh_pkg::HALF_W-1:0]     hb;
    swh_pkg::word_t                 pp_prod;
    logic [swh_pkg::PROD_W-1:0]     term;
    logic                           pp_issue;

    assign ha = cnt_reg[1] ? x_reg[swh_pkg::WORD_W-1:swh_pkg::HALF_W]
                           : x_reg[swh_pkg::HALF_W-1:0];
    assign hb = cnt_reg[0] ? y_reg[swh_pkg::WORD_W-1:swh_pkg::HALF_W]
                           : y_reg[swh_pkg::HALF_W-1:0];
    assign pp_prod  = {{swh_pkg::HALF_W{1'b0}}, ha} * {{swh_pkg::HALF_W{1'b0}}, hb};
    assign pp_issue = cnt_reg < swh_pkg::PP_CNT_W'(swh_pkg::PP_COUNT);

    always_comb
    begin
        unique case (pp_idx_reg)
            2'd0:    term = {{swh_pkg::WORD_W{1'b0}}, pp_reg};
            2'd1,
            2'd2:    term = {{swh_pkg::HALF_W{1'b0}}, pp_reg, {swh_pkg::HALF_W{1'b0}}};
            default: term = {pp_reg, {swh_pkg::WORD_W{1'b0}}};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            cnt_reg      <= '0;
            pp_valid_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg     <= 1'b1;
            cnt_reg      <= '0;
            pp_valid_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            pp_valid_reg <= pp_issue;
            cnt_reg      <= cnt_reg + 1'b1;
            if (!pp_issue)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= x;
            y_reg   <= y;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (pp_issue)
            begin
                pp_reg     <= pp_prod;
                pp_idx_reg <= cnt_reg[1:0];
            end
            if (pp_valid_reg)
            begin
                acc_reg <= acc_reg + term;
            end
        end
    end

    assign busy = busy_reg;
    assign lo   = acc_reg[swh_pkg::WORD_W-1:0];
    assign hi   = acc_reg[swh_pkg::PROD_W-1:swh_pkg::WORD_W];

endmodule

>>> rtl/core/streaming_word_hash_64_unit.sv
// Top level of the streaming 64-bit word hash: sequencer, datapath and buffer.
// Depends on swh_pkg, swh_ifs, swh_ram, swh_mul and the assertion macro header.
//
// Usage: message items enter on msg (word, has_word, last). Each accepted item
// absorbs word when has_word is set; an item with last set finishes the message
// and puts its hash on result. An item with both flags clear is taken and ignored.
// Registers are written on cfg (index 0 seed_base, 1..3 the secrets) and are
// taken only while no item is in progress.
// Timing: the block works on one item at a time; msg.ready is high only between
// items. Every mix runs on the shared multiplier, which builds each 128-bit product
// from 32x32 partial products. The first item of a message also mixes the lane
// seed, a word that arrives on a full buffer (the 7th, 13th and so on) first folds
// the buffer, and a finishing item adds the tail and final mixes, whose number
// depends on how many words are buffered.
// The hash is written to hash_reg once the last multiply is done and stays on result
// until taken; if the previous hash is still waiting, the sequencer holds.
// Reset clears the registers to zero and starts an empty message.
`include "streaming_word_hash_64_unit_defines.svh"

module streaming_word_hash_64_unit (
    input logic        clk,
    input logic        rst_n,
    swh_msg_if.sink    msg,
    swh_hash_if.source result,
    swh_cfg_if.sink    cfg
);

    typedef enum logic {ST_IDLE, ST_RUN} state_t;

    state_t            state_reg, state_next;
    swh_pkg::step_t    step_reg, step_next;
    swh_pkg::cnt_t     cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    swh_pkg::word_t    seed_base_reg, seed_base_next;
    swh_pkg::word_t    secret_zero_reg, secret_zero_next;
    swh_pkg::word_t    secret_one_reg, secret_one_next;
    swh_pkg::word_t    secret_two_reg, secret_two_next;

    swh_pkg::word_t    lane_main_reg, lane_main_next;
    swh_pkg::word_t    lane_one_reg, lane_one_next;
    swh_pkg::word_t    lane_two_reg, lane_two_next;
    swh_pkg::word_t    s_reg, s_next;
    swh_pkg::word_t    t_reg, t_next;
    swh_pkg::word_t    hash_reg, hash_next;
    swh_pkg::word_t    word_reg, word_next;
    logic              has_reg, has_next;
    logic              last_reg, last_next;
    logic              rd_zero_reg, rd_zero_next;

    swh_pkg::ucode_t   uc;
    logic              running;
    logic              hold;
    logic              adv;
    logic              jump;
    logic              msg_acc;
    logic              cfg_acc;
    logic              hash_wr;
    logic              ram_we;
    logic              ram_re;
    swh_pkg::addr_t    ram_raddr;
    swh_pkg::word_t    ram_rdata;
    swh_pkg::word_t    rd_word;
    swh_pkg::cnt_t     tail_n;
    logic              mul_start;
    logic              mul_busy;
    swh_pkg::word_t    mul_x;
    swh_pkg::word_t    mul_y;
    swh_pkg::word_t    mul_lo;
    swh_pkg::word_t    mul_hi;
    swh_pkg::word_t    mix_val;
    swh_pkg::word_t    x_base;
    swh_pkg::word_t    y_base;
    swh_pkg::word_t    y_lane;

    function automatic swh_pkg::word_t key_sel(swh_pkg::key_t k, swh_pkg::word_t s0,
                                               swh_pkg::word_t s1, swh_pkg::word_t s2);
        swh_pkg::word_t v;
        unique case (k)
            swh_pkg::K_S0: v = s0;
            swh_pkg::K_S1: v = s1;
            swh_pkg::K_S2: v = s2;
            default:       v = '0;
        endcase
        return v;
    endfunction

    assign uc      = swh_pkg::swh_ucode(step_reg);
    assign running = state_reg == ST_RUN;
    assign hold    = uc.hold_mul && (mul_busy ||
                     (uc.wb == swh_pkg::WB_HASH && out_valid_reg && !result.ready));
    assign adv     = running && !hold;
    assign hash_wr = adv && uc.wb == swh_pkg::WB_HASH;
    assign msg_acc = msg.valid && msg.ready;
    assign cfg_acc = cfg.valid && cfg.ready;

    assign msg.ready     = state_reg == ST_IDLE;
    assign cfg.ready     = state_reg == ST_IDLE;
    assign result.valid  = out_valid_reg;
    assign result.hash   = hash_reg;

    // Buffer access; entries at or beyond the fill count read as zero padding.
    assign tail_n  = (cnt_reg < swh_pkg::cnt_t'(2)) ? swh_pkg::cnt_t'(2) : cnt_reg;
    assign rd_word = rd_zero_reg ? '0 : ram_rdata;
    assign ram_re  = running && uc.rd;
    assign ram_we  = adv && uc.cnt_op == swh_pkg::CNT_PUSH && has_reg;

    always_comb
    begin
        unique case (uc.amode)
            swh_pkg::AM_TAIL2: ram_raddr = swh_pkg::addr_t'(tail_n - swh_pkg::cnt_t'(2));
            swh_pkg::AM_TAIL1: ram_raddr = swh_pkg::addr_t'(tail_n - swh_pkg::cnt_t'(1));
            default:           ram_raddr = uc.addr;
        endcase
    end

    swh_ram #(
        .WIDTH (swh_pkg::WORD_W),
        .DEPTH (swh_pkg::BUF_DEPTH)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (swh_pkg::addr_t'(cnt_reg)),
        .wdata (word_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Multiplier operands.
    always_comb
    begin
        unique case (uc.xs)
            swh_pkg::XS_SEED: x_base = seed_base_reg;
            swh_pkg::XS_LO:   x_base = mul_lo;
            default:          x_base = t_reg;
        endcase
        unique case (uc.ys)
            swh_pkg::YS_ZERO: y_base = '0;
            swh_pkg::YS_HI:   y_base = mul_hi;
            default:          y_base = rd_word;
        endcase
        unique case (uc.yl)
            swh_pkg::L_MAIN: y_lane = lane_main_reg;
            swh_pkg::L_ONE:  y_lane = lane_one_reg;
            swh_pkg::L_TWO:  y_lane = lane_two_reg;
            swh_pkg::L_S:    y_lane = s_reg;
            default:         y_lane = '0;
        endcase
    end

    assign mul_x     = x_base ^ key_sel(uc.xk, secret_zero_reg, secret_one_reg, secret_two_reg);
    assign mul_y     = y_base ^ y_lane
                       ^ key_sel(uc.yk, secret_zero_reg, secret_one_reg, secret_two_reg);
    assign mul_start = running && uc.go;
    assign mix_val   = mul_lo ^ mul_hi;

    swh_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .x     (mul_x),
        .y     (mul_y),
        .busy  (mul_busy),
        .lo    (mul_lo),
        .hi    (mul_hi)
    );

    always_comb
    begin
        unique case (uc.cond)
            swh_pkg::C_ALWAYS:  jump = 1'b1;
            swh_pkg::C_CNT_NZ:  jump = cnt_reg != '0;
            swh_pkg::C_NO_FOLD: jump = !(has_reg &&
                                         cnt_reg == swh_pkg::cnt_t'(swh_pkg::BUF_DEPTH));
            swh_pkg::C_NO_LAST: jump = !last_reg;
            swh_pkg::C_N_LE2:   jump = cnt_reg <= swh_pkg::cnt_t'(2);
            swh_pkg::C_N_LE4:   jump = cnt_reg <= swh_pkg::cnt_t'(4);
            default:            jump = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        step_next        = step_reg;
        cnt_next         = cnt_reg;
        out_valid_next   = out_valid_reg;
        seed_base_next   = seed_base_reg;
        secret_zero_next = secret_zero_reg;
        secret_one_next  = secret_one_reg;
        secret_two_next  = secret_two_reg;
        lane_main_next   = lane_main_reg;
        lane_one_next    = lane_one_reg;
        lane_two_next    = lane_two_reg;
        s_next           = s_reg;
        t_next           = t_reg;
        hash_next        = hash_reg;
        word_next        = word_reg;
        has_next         = has_reg;
        last_next        = last_reg;
        rd_zero_next     = rd_zero_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (msg_acc)
                begin
                    word_next = msg.word;
                    has_next  = msg.has_word;
                    last_next = msg.last;
                    if (msg.has_word || msg.last)
                    begin
                        state_next = ST_RUN;
                        step_next  = '0;
                    end
                end
            end
            ST_RUN:
            begin
                if (!hold)
                begin
                    if (uc.done)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (jump)
                    begin
                        step_next = uc.target;
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
        endcase

        if (ram_re)
        begin
            rd_zero_next = {1'b0, ram_raddr} >= {1'b0, cnt_reg};
        end
        if (running && uc.ld_t)
        begin
            t_next = rd_word;
        end
        if (running && uc.s_init)
        begin
            s_next = lane_main_reg ^ lane_one_reg ^ lane_two_reg;
        end

        if (adv)
        begin
            unique case (uc.wb)
                swh_pkg::WB_SEED:
                begin
                    lane_main_next = seed_base_reg ^ mix_val;
                    lane_one_next  = seed_base_reg ^ mix_val;
                    lane_two_next  = seed_base_reg ^ mix_val;
                end
                swh_pkg::WB_MAIN: lane_main_next = mix_val;
                swh_pkg::WB_ONE:  lane_one_next  = mix_val;
                swh_pkg::WB_TWO:  lane_two_next  = mix_val;
                swh_pkg::WB_S:    s_next         = mix_val;
                swh_pkg::WB_HASH: hash_next      = mix_val;
                default:
                begin
                end
            endcase
            unique case (uc.cnt_op)
                swh_pkg::CNT_CLEAR: cnt_next = '0;
                swh_pkg::CNT_PUSH:
                begin
                    if (has_reg)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (hash_wr)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_acc)
        begin
            unique case (swh_pkg::reg_idx_t'(cfg.index))
                swh_pkg::REG_SEED_BASE:   seed_base_next   = cfg.data;
                swh_pkg::REG_SECRET_ZERO: secret_zero_next = cfg.data;
                swh_pkg::REG_SECRET_ONE:  secret_one_next  = cfg.data;
                swh_pkg::REG_SECRET_TWO:  secret_two_next  = cfg.data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            step_reg        <= '0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
            seed_base_reg   <= '0;
            secret_zero_reg <= '0;
            secret_one_reg  <= '0;
            secret_two_reg  <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            step_reg        <= step_next;
            cnt_reg         <= cnt_next;
            out_valid_reg   <= out_valid_next;
            seed_base_reg   <= seed_base_next;
            secret_zero_reg <= secret_zero_next;
            secret_one_reg  <= secret_one_next;
            secret_two_reg  <= secret_two_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lane_main_reg <= lane_main_next;
        lane_one_reg  <= lane_one_next;
        lane_two_reg  <= lane_two_next;
        s_reg         <= s_next;
        t_reg         <= t_next;
        hash_reg      <= hash_next;
        word_reg      <= word_next;
        has_reg       <= has_next;
        last_reg      <= last_next;
        rd_zero_reg   <= rd_zero_next;
    end

    `SWH_ASSERT_IMPL(a_idle_mul_quiet, state_reg == ST_IDLE, !mul_busy)
    `SWH_ASSERT_IMPL(a_cnt_in_range, 1'b1, cnt_reg <= swh_pkg::cnt_t'(swh_pkg::BUF_DEPTH))
    `SWH_ASSERT_IMPL(a_hash_slot_free, hash_wr, !out_valid_reg || result.ready)
    `SWH_ASSERT_NEXT(a_work_starts, msg_acc && (msg.has_word || msg.last), state_reg == ST_RUN)

endmodule
